/* rtl/sgff_pkg.sv */
`timescale 1ns / 1ps
// Shared types and fixed constants for the softened gravity far-field sum.
// Used by sgff_ctrl, sgff_dp and the top level.
package sgff_pkg;

  localparam int NODE_W    = 16;   // node offset, Q1.14
  localparam int NODE_FRAC = 14;
  localparam int WEIGHT_W  = 32;
  localparam int GRAV_W    = 32;
  localparam int BASE_W    = 64;   // gravity * |weight|
  localparam int OUT_FRAC  = 32;
  localparam int NORM_W    = 84;   // normalized radicand bound, 2^84
  localparam int ROOT_W    = 42;
  localparam int DEN_W     = 126;  // radicand * root

  localparam logic [GRAV_W-1:0] GRAV_RESET = 32'h0100_0000;

  localparam logic REG_SOFTENING = 1'b0;
  localparam logic REG_GRAVITY   = 1'b1;

  // operand routing of the shared multiplier
  typedef enum logic [1:0] {
    MSEL_SOFT = 2'd0,
    MSEL_DSQ  = 2'd1,
    MSEL_DEN  = 2'd2,
    MSEL_NUM  = 2'd3
  } msel_t;

  typedef struct packed {
    logic       load;
    logic       point;
    logic       diff;
    logic       mul_start;
    msel_t      mul_sel;
    logic [1:0] lane;
    logic       norm;
    logic       sqrt_start;
    logic       div_start;
    logic       accum;
    logic       set_err;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic       g_zero;
    logic       w_zero;
    logic       s_zero;
    logic       s_big;
    logic       mul_done;
    logic       sqrt_done;
    logic       div_done;
    logic       div_ovf;
    logic [2:0] d_zero;
    logic       last;
    logic       out_busy;
  } stat_t;

endpackage

/* rtl/softened_gravity_far_field_sum.sv */
`timescale 1ns / 1ps
// Top level of the softened gravity far-field sum: sequencer plus datapath.
// Depends on sgff_pkg, sgff_ctrl, sgff_dp (and sgff_mul below it).
//
//  channel  | handshake            | content
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_ready  | cell center, half side, node, weight,
//           |                      | target, last_node
//  out      | out_valid / out_ready| accel_x/y/z (Q15.32, saturated), status
//  cfg      | cfg_valid / cfg_ready| cfg_index (0 softening, 1 gravity), cfg_data
//
// One word at a time. A word with zero weight or zero gravity skips the
// arithmetic. Otherwise a word uses up to eight products on the shared
// radix-16 multiplier, a 42-step square root and up to three dividers of
// SUM_WIDTH-1 steps; the divider steps dominate. A huge radicand is first
// scaled down by factors of four.
// Reset clears the sums, the sticky error flag and the result valid; no clearing pass.
// A result held by out_ready low stalls only the word that carries last_node.
module softened_gravity_far_field_sum #(
  parameter int  COORD_WIDTH = 32,
  parameter int  SUM_WIDTH   = 48,
  localparam int CFG_W = (COORD_WIDTH - 1 > 32) ? COORD_WIDTH - 1 : 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] center_x,
  input  logic [COORD_WIDTH-1:0] center_y,
  input  logic [COORD_WIDTH-1:0] center_z,
  input  logic [COORD_WIDTH-2:0] half_side,
  input  logic [15:0]            node_x,
  input  logic [15:0]            node_y,
  input  logic [15:0]            node_z,
  input  logic [31:0]            weight,
  input  logic [COORD_WIDTH-1:0] target_x,
  input  logic [COORD_WIDTH-1:0] target_y,
  input  logic [COORD_WIDTH-1:0] target_z,
  input  logic                   last_node,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SUM_WIDTH-1:0]   accel_x,
  output logic [SUM_WIDTH-1:0]   accel_y,
  output logic [SUM_WIDTH-1:0]   accel_z,
  output logic                   status,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  sgff_pkg::cmd_t             cmd;
  sgff_pkg::stat_t            stat;
  logic [2:0][SUM_WIDTH-1:0]  accel;

  assign cfg_ready = 1'b1;
  assign accel_x   = accel[0];
  assign accel_y   = accel[1];
  assign accel_z   = accel[2];

  sgff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sgff_dp #(.CW(COORD_WIDTH), .SW(SUM_WIDTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .center      ({center_z, center_y, center_x}),
    .half_side   (half_side),
    .node        ({node_z, node_y, node_x}),
    .weight      (weight),
    .target      ({target_z, target_y, target_x}),
    .last_node   (last_node),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .accel       (accel),
    .status      (status)
  );

endmodule

/* rtl/sgff_mul.sv */
`timescale 1ns / 1ps
// Radix-16 shift-add multiplier, one multiplier digit per cycle.
// Stand-alone; shared by the radicand, den and num products of sgff_dp.
module sgff_mul #(
  parameter int AW = 84,
  parameter int BW = 42
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int PW = AW + BW;

  logic [PW-1:0] mcand;
  logic [BW-1:0] mplier;
  logic [PW-1:0] part;

  always_comb begin
    part = (mplier[0] ? mcand : '0) + (mplier[1] ? (mcand << 1) : '0) +
           (mplier[2] ? (mcand << 2) : '0) + (mplier[3] ? (mcand << 3) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && mplier == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // stop as soon as no multiplier digits remain
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= PW'(a);
      mplier <= b;
      prod   <= '0;
    end else if (busy && mplier != '0) begin
      prod   <= prod + part;
      mcand  <= mcand << 4;
      mplier <= mplier >> 4;
    end
  end

endmodule

/* rtl/sgff_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for one node interaction: issues datapath commands, reads status.
// Depends on sgff_pkg.
module sgff_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sgff_pkg::stat_t stat,
  output sgff_pkg::cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0_0000_0000_0001,
    S_POINT  = 13'b0_0000_0000_0010,
    S_DIFF   = 13'b0_0000_0000_0100,
    S_MUL    = 13'b0_0000_0000_1000,
    S_MWAIT  = 13'b0_0000_0001_0000,
    S_NORM   = 13'b0_0000_0010_0000,
    S_SQRT   = 13'b0_0000_0100_0000,
    S_SWAIT  = 13'b0_0000_1000_0000,
    S_LANE   = 13'b0_0001_0000_0000,
    S_DIV    = 13'b0_0010_0000_0000,
    S_DWAIT  = 13'b0_0100_0000_0000,
    S_ACCUM  = 13'b0_1000_0000_0000,
    S_FINISH = 13'b1_0000_0000_0000
  } state_t;

  state_t                state, state_next;
  sgff_pkg::msel_t       msel, msel_next;
  logic [1:0]            lane, lane_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    msel_next  = msel;
    lane_next  = lane;
    cmd        = '0;
    cmd.mul_sel = msel;
    cmd.lane    = lane;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_POINT;
        end
      end
      S_POINT: begin
        cmd.point = 1'b1;
        if (stat.g_zero) begin
          cmd.set_err = 1'b1;
          state_next  = S_FINISH;
        end else if (stat.w_zero) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        msel_next  = sgff_pkg::MSEL_SOFT;
        lane_next  = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        if (stat.mul_done) begin
          unique case (msel)
            sgff_pkg::MSEL_SOFT: begin
              msel_next  = sgff_pkg::MSEL_DSQ;
              state_next = S_MUL;
            end
            sgff_pkg::MSEL_DSQ: begin
              if (lane == 2'd2) begin
                state_next = S_NORM;
              end else begin
                lane_next  = lane + 2'd1;
                state_next = S_MUL;
              end
            end
            sgff_pkg::MSEL_DEN: begin
              lane_next  = '0;
              state_next = S_LANE;
            end
            sgff_pkg::MSEL_NUM: state_next = S_DIV;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_NORM: begin
        if (stat.s_zero) begin
          cmd.set_err = 1'b1;
          state_next  = S_FINISH;
        end else if (stat.s_big) begin
          cmd.norm = 1'b1;
        end else begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SWAIT;
      end
      S_SWAIT: begin
        if (stat.sqrt_done) begin
          msel_next  = sgff_pkg::MSEL_DEN;
          state_next = S_MUL;
        end
      end
      S_LANE: begin
        // a zero displacement component contributes zero, skip its division
        if (stat.d_zero[lane]) begin
          if (lane == 2'd2) begin
            state_next = S_ACCUM;
          end else begin
            lane_next = lane + 2'd1;
          end
        end else begin
          msel_next  = sgff_pkg::MSEL_NUM;
          state_next = S_MUL;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          if (stat.div_ovf) begin
            cmd.set_err = 1'b1;
            state_next  = S_FINISH;
          end else if (lane == 2'd2) begin
            state_next = S_ACCUM;
          end else begin
            lane_next  = lane + 2'd1;
            state_next = S_LANE;
          end
        end
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.last) begin
          state_next = S_IDLE;
        end else if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      msel  <= sgff_pkg::MSEL_SOFT;
      lane  <= '0;
    end else begin
      state <= state_next;
      msel  <= msel_next;
      lane  <= lane_next;
    end
  end

endmodule

/* rtl/sgff_dp.sv */
`timescale 1ns / 1ps
// Datapath: configuration, node geometry, shared multiplier, root, divider,
// saturating sums and the output word register. Depends on sgff_pkg, sgff_mul.
module sgff_dp #(
  parameter int  CW = 32,
  parameter int  SW = 48,
  localparam int CFG_W = (CW - 1 > 32) ? CW - 1 : 32
) (
  input  logic                clk,
  input  logic                rst,
  input  sgff_pkg::cmd_t      cmd,
  output sgff_pkg::stat_t     stat,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [2:0][CW-1:0]  center,
  input  logic [CW-2:0]       half_side,
  input  logic [2:0][15:0]    node,
  input  logic [31:0]         weight,
  input  logic [2:0][CW-1:0]  target,
  input  logic                last_node,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [2:0][SW-1:0]  accel,
  output logic                status
);

  localparam int PPW  = CW + sgff_pkg::NODE_W;
  localparam int DW3  = CW + 3;
  localparam int MW   = CW + 2;
  localparam int SSW  = (2 * CW + 5 > sgff_pkg::NORM_W + 2) ? 2 * CW + 5
                                                              : sgff_pkg::NORM_W + 2;
  localparam int MAW  = (MW > sgff_pkg::NORM_W) ? MW : sgff_pkg::NORM_W;
  localparam int MBW  = (MW > sgff_pkg::ROOT_W) ? MW : sgff_pkg::ROOT_W;
  localparam int PW   = MAW + MBW;
  localparam int NUMW = sgff_pkg::BASE_W + MW;
  localparam int NW   = (NUMW + sgff_pkg::OUT_FRAC > sgff_pkg::DEN_W + 1)
                        ? NUMW + sgff_pkg::OUT_FRAC : sgff_pkg::DEN_W + 1;
  localparam int QW   = SW - 1;
  localparam int QCW  = $clog2(QW + 1);
  localparam int RCW  = $clog2(sgff_pkg::ROOT_W + 1);

  // configuration
  logic [CW-2:0]                 softening;
  logic [sgff_pkg::GRAV_W-1:0]   grav;

  // latched word
  logic [CW-1:0]    ctr [3];
  logic [CW-1:0]    tgt [3];
  logic [15:0]      nd  [3];
  logic [CW-2:0]    he;
  logic [31:0]      wt;
  logic             last;

  logic signed [PPW-1:0] pp   [3];
  logic [MW-1:0]         dmag [3];
  logic [2:0]            dneg;
  logic [sgff_pkg::BASE_W-1:0] base;
  logic [SSW-1:0]        s;
  logic [4:0]            m;
  logic [sgff_pkg::DEN_W-1:0] den;
  logic [NUMW-1:0]       num;
  logic [QW-1:0]         qv   [3];
  logic signed [SW-1:0]  sums [3];
  logic                  err;

  // multiplier
  logic [MAW-1:0]   mul_a;
  logic [MBW-1:0]   mul_b;
  logic [PW-1:0]    prod;
  logic             mul_busy, mul_done;
  sgff_pkg::msel_t  msel_q;
  logic [1:0]       mlane_q;

  // root
  logic [sgff_pkg::NORM_W-1:0] rad;
  logic [sgff_pkg::ROOT_W+1:0] srem;
  logic [sgff_pkg::ROOT_W-1:0] root;
  logic [RCW-1:0]              scnt;
  logic                        sqrt_busy, sqrt_done;

  // divider
  logic [sgff_pkg::DEN_W-1:0] drem;
  logic [QW-1:0]              nlow, dq;
  logic [QCW-1:0]             dcnt;
  logic                       div_busy, div_done, div_ovf;
  logic [1:0]                 dlane_q;

  // combinational helpers
  logic signed [DW3-1:0] d_next [3];
  logic signed [PPW-1:0] off;
  logic [31:0]           wmag;
  logic [6:0]            e3;
  logic [5:0]            ext;
  logic [NW-1:0]         nfull, nhi;
  logic                  ovf_now;
  logic [sgff_pkg::ROOT_W+3:0] rem2, trial;
  logic                        sbit;
  logic [sgff_pkg::DEN_W:0]    r2;
  logic                        dbit;
  logic signed [SW:0]          qx, cv, tot;
  logic signed [SW-1:0]        sum_next [3];

  // ---------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      softening <= '0;
      grav      <= sgff_pkg::GRAV_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sgff_pkg::REG_SOFTENING: softening <= cfg_data[CW-2:0];
        sgff_pkg::REG_GRAVITY:   grav      <= cfg_data[sgff_pkg::GRAV_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- geometry
  always_comb begin
    off = '0;
    for (int k = 0; k < 3; k++) begin
      off       = pp[k] >>> sgff_pkg::NODE_FRAC;
      d_next[k] = DW3'($signed(ctr[k])) + DW3'(off) - DW3'($signed(tgt[k]));
    end
    wmag = wt[31] ? (~wt + 32'd1) : wt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        ctr[k] <= center[k];
        tgt[k] <= target[k];
        nd[k]  <= node[k];
      end
      he   <= half_side;
      wt   <= weight;
      last <= last_node;
    end
    if (cmd.point) begin
      for (int k = 0; k < 3; k++) begin
        pp[k] <= $signed({1'b0, he}) * $signed(nd[k]);
      end
    end
    if (cmd.diff) begin
      for (int k = 0; k < 3; k++) begin
        dneg[k] <= d_next[k][DW3-1];
        dmag[k] <= d_next[k][DW3-1] ? MW'(-d_next[k]) : MW'(d_next[k]);
      end
      base <= grav * wmag;
    end
  end

  // ---------------- shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      sgff_pkg::MSEL_SOFT: begin
        mul_a = MAW'(softening);
        mul_b = MBW'(softening);
      end
      sgff_pkg::MSEL_DSQ: begin
        mul_a = MAW'(dmag[cmd.lane]);
        mul_b = MBW'(dmag[cmd.lane]);
      end
      sgff_pkg::MSEL_DEN: begin
        mul_a = MAW'(s[sgff_pkg::NORM_W-1:0]);
        mul_b = MBW'(root);
      end
      sgff_pkg::MSEL_NUM: begin
        mul_a = MAW'(base);
        mul_b = MBW'(dmag[cmd.lane]);
      end
      default: ;
    endcase
  end

  sgff_mul #(.AW(MAW), .BW(MBW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      msel_q  <= cmd.mul_sel;
      mlane_q <= cmd.lane;
    end
  end

  // products land here: radicand (scaled down by four until below 2^84), den, num
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      m <= '0;
    end
    if (mul_done) begin
      case (msel_q)
        sgff_pkg::MSEL_SOFT: s   <= SSW'(prod);
        sgff_pkg::MSEL_DSQ:  s   <= s + SSW'(prod);
        sgff_pkg::MSEL_DEN:  den <= prod[sgff_pkg::DEN_W-1:0];
        sgff_pkg::MSEL_NUM:  num <= prod[NUMW-1:0];
        default: ;
      endcase
    end else if (cmd.norm) begin
      s <= s >> 2;
      m <= m + 5'd1;
    end
  end

  // ---------------- square root, one result bit per cycle
  always_comb begin
    rem2  = {srem, rad[sgff_pkg::NORM_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    sbit  = (rem2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_busy <= 1'b0;
      sqrt_done <= 1'b0;
    end else begin
      sqrt_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sqrt_busy <= 1'b1;
      end else if (sqrt_busy && scnt == RCW'(1)) begin
        sqrt_busy <= 1'b0;
        sqrt_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rad  <= s[sgff_pkg::NORM_W-1:0];
      srem <= '0;
      root <= '0;
      scnt <= RCW'(sgff_pkg::ROOT_W);
    end else if (sqrt_busy) begin
      srem <= sbit ? (sgff_pkg::ROOT_W + 2)'(rem2 - trial)
                   : (sgff_pkg::ROOT_W + 2)'(rem2);
      root <= {root[sgff_pkg::ROOT_W-2:0], sbit};
      rad  <= rad << 2;
      scnt <= scnt - RCW'(1);
    end
  end

  // ---------------- divider: quotient of (num << extra) by den
  always_comb begin
    e3      = 7'(m) * 7'd3;
    ext     = (e3 < 7'(sgff_pkg::OUT_FRAC)) ? 6'(7'(sgff_pkg::OUT_FRAC) - e3) : '0;
    nfull   = NW'(num) << ext;
    nhi     = nfull >> QW;
    // quotient above the sum limit exactly when the top part reaches den
    ovf_now = (nhi >= NW'(den));
    r2      = {drem, nlow[QW-1]};
    dbit    = (r2 >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (cmd.div_start) begin
        div_busy <= !ovf_now;
        div_done <= ovf_now;
      end else if (div_busy && dcnt == QCW'(1)) begin
        div_busy <= 1'b0;
        div_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_ovf <= ovf_now;
      dlane_q <= cmd.lane;
      drem    <= nhi[sgff_pkg::DEN_W-1:0];
      nlow    <= nfull[QW-1:0];
      dq      <= '0;
      dcnt    <= QCW'(QW);
    end else if (div_busy) begin
      drem <= dbit ? sgff_pkg::DEN_W'(r2 - {1'b0, den}) : sgff_pkg::DEN_W'(r2);
      dq   <= {dq[QW-2:0], dbit};
      nlow <= nlow << 1;
      dcnt <= dcnt - QCW'(1);
    end
    // clear the quotients for a new word; skipped lanes stay zero
    if (cmd.diff) begin
      for (int k = 0; k < 3; k++) begin
        qv[k] <= '0;
      end
    end
    if (div_done && !div_ovf) begin
      qv[dlane_q] <= dq;
    end
  end

  // ---------------- saturating sums and output word
  always_comb begin
    qx  = '0;
    cv  = '0;
    tot = '0;
    for (int k = 0; k < 3; k++) begin
      qx  = (SW + 1)'({2'b00, qv[k]});
      cv  = (dneg[k] ^ wt[31]) ? -qx : qx;
      tot = {sums[k][SW-1], sums[k]} + cv;
      if (tot[SW] != tot[SW-1]) begin
        sum_next[k] = tot[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
        sum_next[k] = tot[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        sums[k] <= '0;
      end
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.set_err) begin
        err <= 1'b1;
      end
      if (cmd.accum) begin
        for (int k = 0; k < 3; k++) begin
          sums[k] <= sum_next[k];
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        err       <= 1'b0;
        for (int k = 0; k < 3; k++) begin
          sums[k] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      for (int k = 0; k < 3; k++) begin
        accel[k] <= sums[k];
      end
      status <= err;
    end
  end

  // ---------------- status to the sequencer
  always_comb begin
    stat           = '0;
    stat.g_zero    = (grav == '0);
    stat.w_zero    = (wt == '0);
    stat.s_zero    = (s == '0);
    stat.s_big     = |s[SSW-1:sgff_pkg::NORM_W];
    stat.mul_done  = mul_done;
    stat.sqrt_done = sqrt_done;
    stat.div_done  = div_done;
    stat.div_ovf   = div_ovf;
    for (int k = 0; k < 3; k++) begin
      stat.d_zero[k] = (dmag[k] == '0);
    end
    stat.last      = last;
    stat.out_busy  = out_valid && !out_ready;
  end

  // ---------------- checks
  a_root_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sqrt_start |-> !stat.s_big && !stat.s_zero)
    else $error("root started on a zero or unscaled radicand");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_start || cmd.mul_start) |-> !div_busy && !sqrt_busy && !mul_busy)
    else $error("arithmetic unit started while another is busy");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    err && !cmd.emit |=> err)
    else $error("status bit dropped before the result word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("result word overwritten while waiting");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench for softened_gravity_far_field_sum: directed table, then random node groups.
// Depends on sgff_pkg and the top level; a wide-integer model predicts each untyped result.
module tb;

  localparam int CW = 32;
  localparam int SW = 48;
  localparam longint SUM_MAX = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam int SETTLE = 500;

  typedef struct {
    logic signed [CW-1:0] cx, cy, cz;
    logic [CW-2:0]        he;
    logic signed [15:0]   nx, ny, nz;
    logic signed [31:0]   w;
    logic signed [CW-1:0] tx, ty, tz;
    logic                 last;
  } node_t;

  typedef struct {
    logic [SW-1:0] x, y, z;
    logic          st;
  } accel_t;

  typedef struct {
    node_t  n;
    bit     typed;
    accel_t a;
  } row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [CW-1:0] center_x, center_y, center_z, target_x, target_y, target_z;
  logic [CW-2:0] half_side;
  logic [15:0] node_x, node_y, node_z;
  logic [31:0] weight;
  logic last_node;
  logic [SW-1:0] accel_x, accel_y, accel_z;
  logic status;
  logic cfg_index;
  logic [31:0] cfg_data;

  softened_gravity_far_field_sum i_dut (.*);

  // local copy of block state and registers
  longint acc_x, acc_y, acc_z;
  bit err_sticky;
  logic [CW-2:0] soft_len;
  logic [31:0] grav;

  accel_t accel_q[$];
  int mismatches;
  bit long_hold;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint sat_sum(longint a, longint c);
    if (c > 0 && a > SUM_MAX - c) return SUM_MAX;
    if (c < 0 && a < SUM_MIN - c) return SUM_MIN;
    return a + c;
  endfunction

  function automatic longint axis_diff(logic signed [CW-1:0] c, logic [CW-2:0] he,
                                       logic signed [15:0] n, logic signed [CW-1:0] t);
    longint off;
    off = (longint'({1'b0, he}) * longint'(n)) >>> sgff_pkg::NODE_FRAC;
    return longint'(c) + off - longint'(t);
  endfunction

  // accumulate one node; returns 1 with the acceleration word when last is set
  function automatic bit accumulate_node(node_t n, output accel_t a);
    longint d[3];
    logic [63:0] md[3], root, cand, base;
    logic [127:0] s, sq, den, numer;
    logic [255:0] quo;
    longint q[3], cv;
    int m, extra;
    bit ok;
    if (grav == 0) err_sticky = 1;
    else if (n.w != 0) begin
      d[0] = axis_diff(n.cx, n.he, n.nx, n.tx);
      d[1] = axis_diff(n.cy, n.he, n.ny, n.ty);
      d[2] = axis_diff(n.cz, n.he, n.nz, n.tz);
      sq = soft_len;
      s = sq * sq;
      for (int k = 0; k < 3; k++) begin
        md[k] = d[k] < 0 ? -d[k] : d[k];
        sq = md[k];
        s = s + sq * sq;
      end
      if (s == 0) err_sticky = 1;
      else begin
        m = 0;
        while (s >= (128'd1 << 84)) begin
          s = s >> 2;
          m++;
        end
        extra = (3 * m < 32) ? 32 - 3 * m : 0;
        root = 0;
        for (int b = 63; b >= 0; b--) begin
          cand = root | (64'd1 << b);
          sq = cand;
          if (sq * sq <= s) root = cand;
        end
        sq = root;
        den = s * sq;
        base = 64'(grav) * 64'(n.w < 0 ? -longint'(n.w) : longint'(n.w));
        ok = 1;
        for (int k = 0; k < 3; k++) begin
          numer = base;
          sq = md[k];
          numer = numer * sq;
          quo = {128'd0, numer} << extra;
          quo = quo / {128'd0, den};
          if (quo > 256'(SUM_MAX)) ok = 0;
          q[k] = longint'(quo[63:0]);
        end
        if (!ok) err_sticky = 1;
        else begin
          for (int k = 0; k < 3; k++) begin
            cv = ((n.w < 0) != (d[k] < 0)) ? -q[k] : q[k];
            if (k == 0) acc_x = sat_sum(acc_x, cv);
            else if (k == 1) acc_y = sat_sum(acc_y, cv);
            else acc_z = sat_sum(acc_z, cv);
          end
        end
      end
    end
    if (!n.last) return 0;
    a.x = acc_x[SW-1:0];
    a.y = acc_y[SW-1:0];
    a.z = acc_z[SW-1:0];
    a.st = err_sticky;
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    err_sticky = 0;
    return 1;
  endfunction

  // result check
  always @(posedge clk) begin
    accel_t e;
    if (!rst && out_valid && out_ready) begin
      if (accel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word");
      end else begin
        e = accel_q.pop_front();
        if (accel_x !== e.x || accel_y !== e.y || accel_z !== e.z || status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp %h %h %h st %b, got %h %h %h st %b",
                     e.x, e.y, e.z, e.st, accel_x, accel_y, accel_z, status);
        end
      end
    end
  end

  // receiver: random stalls, one long hold on request
  initial begin
    int r;
    out_ready = 0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (4000) @(posedge clk);
        long_hold = 0;
      end else begin
        r = $urandom_range(0, 9);
        out_ready <= (r < 6);
        if (r < 6) repeat ($urandom_range(1, 20)) @(posedge clk);
        else if (r < 9) repeat ($urandom_range(1, 3)) @(posedge clk);
        else repeat ($urandom_range(20, 200)) @(posedge clk);
      end
    end
  end

  task automatic sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return;
    in_valid <= 0;
    if (r < 95) repeat ($urandom_range(1, 3)) @(posedge clk);
    else repeat ($urandom_range(20, 300)) @(posedge clk);
  endtask

  task automatic send_node(node_t n, bit typed, accel_t typed_val);
    accel_t a;
    in_valid <= 1;
    center_x <= n.cx;
    center_y <= n.cy;
    center_z <= n.cz;
    half_side <= n.he;
    node_x <= n.nx;
    node_y <= n.ny;
    node_z <= n.nz;
    weight <= n.w;
    target_x <= n.tx;
    target_y <= n.ty;
    target_z <= n.tz;
    last_node <= n.last;
    do @(posedge clk); while (!in_ready);
    if (accumulate_node(n, a)) accel_q.push_back(typed ? typed_val : a);
    sender_gap();
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (accel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == sgff_pkg::REG_SOFTENING) soft_len = val[CW-2:0];
    else grav = val;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    if (mode == 0) return $urandom;
    return $signed($urandom_range(0, 32'h1fff_ffff)) - 32'sh1000_0000;
  endfunction

  function automatic node_t rand_node(logic signed [CW-1:0] t[3]);
    node_t n;
    int mode;
    mode = $urandom_range(0, 9);
    n.cx = rand_coord(mode);
    n.cy = rand_coord(mode);
    n.cz = rand_coord(mode);
    n.he = mode == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h03ff_ffff));
    n.nx = mode == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 32768)) - 16384);
    n.ny = mode == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 32768)) - 16384);
    n.nz = mode == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 32768)) - 16384);
    n.w = mode == 0 ? $urandom : $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
    n.tx = mode == 0 ? 32'($urandom) : t[0];
    n.ty = mode == 0 ? 32'($urandom) : t[1];
    n.tz = mode == 0 ? 32'($urandom) : t[2];
    if (mode == 8) n.w = 0;
    if (mode == 9) begin
      // coincident point: zero distance unless softening is set
      n.nx = 0; n.ny = 0; n.nz = 0;
      n.cx = n.tx; n.cy = n.ty; n.cz = n.tz;
    end
    n.last = 0;
    return n;
  endfunction

  task automatic random_groups(int count, bit hold_once);
    logic signed [CW-1:0] t[3];
    node_t n;
    accel_t none;
    int len, sent;
    sent = 0;
    none = '{default: '0};
    while (sent < count) begin
      if (hold_once && sent > count / 2) begin
        long_hold = 1;
        hold_once = 0;
      end
      t[0] = rand_coord(1);
      t[1] = rand_coord(1);
      t[2] = rand_coord(1);
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        n = rand_node(t);
        n.last = (i == len - 1);
        send_node(n, 0, none);
        sent++;
      end
    end
  endtask

  row_t rows[$];

  function automatic node_t mk(logic signed [31:0] cx, logic signed [31:0] cy,
                               logic signed [31:0] cz, logic [30:0] he,
                               logic signed [15:0] nx, logic signed [15:0] ny,
                               logic signed [15:0] nz, logic signed [31:0] w,
                               logic signed [31:0] tx, logic signed [31:0] ty,
                               logic signed [31:0] tz, logic last);
    node_t n;
    n = '{cx, cy, cz, he, nx, ny, nz, w, tx, ty, tz, last};
    return n;
  endfunction

  initial begin
    accel_t zero_ok, zero_bad, unit_x;
    localparam logic signed [31:0] ONE = 32'sh0100_0000;
    localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] CMIN = -32'sh7fff_ffff - 1;
    rst = 1;
    in_valid = 0;
    cfg_valid = 0;
    cfg_index = sgff_pkg::REG_SOFTENING;
    cfg_data = 0;
    {center_x, center_y, center_z, target_x, target_y, target_z} = '0;
    {half_side, node_x, node_y, node_z, weight, last_node} = '0;
    long_hold = 0;
    mismatches = 0;
    acc_x = 0; acc_y = 0; acc_z = 0;
    err_sticky = 0;
    soft_len = 0;
    grav = sgff_pkg::GRAV_RESET;
    zero_ok = '{default: '0};
    zero_bad = '{x: '0, y: '0, z: '0, st: 1'b1};
    unit_x = '{x: 48'h1_0000_0000, y: '0, z: '0, st: 1'b0};

    rows.push_back('{mk(ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, zero_ok});
    rows.push_back('{mk(5, 6, 7, 0, 0, 0, 0, ONE, 5, 6, 7, 1), 1, zero_bad});
    rows.push_back('{mk(ONE, 0, 0, 0, 0, 0, 0, ONE, 0, 0, 0, 1), 1, unit_x});
    rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0, CMAX, 0, 0, 0, 1), 1, zero_bad});
    rows.push_back('{mk(CMAX, CMAX, CMAX, 31'h7fff_ffff, 16'sh7fff, -16'sh8000, 16'sh7fff,
                        CMIN, CMIN, CMIN, CMIN, 1), 0, zero_ok});
    rows.push_back('{mk(CMIN, CMAX, CMIN, 31'h7fff_ffff, -16'sh8000, 16'sh7fff, -16'sh8000,
                        CMAX, CMAX, CMIN, CMAX, 1), 0, zero_ok});
    rows.push_back('{mk(CMAX, 0, 0, 0, 0, 0, 0, -ONE, CMIN, 0, 0, 1), 0, zero_ok});
    // accumulate several nodes, one of them coincident, then emit
    rows.push_back('{mk(ONE, ONE, 0, ONE, 16384, 0, -16384, ONE, 0, 0, 0, 0), 0, zero_ok});
    rows.push_back('{mk(-ONE, 0, ONE, ONE / 2, -8192, 8192, 0, -ONE, 0, 0, 0, 0), 0, zero_ok});
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_ok});
    rows.push_back('{mk(3, 4, 0, 0, 0, 0, 0, ONE, 0, 0, 0, 1), 0, zero_ok});
    rows.push_back('{mk(ONE, -ONE, ONE, 100, 1, -1, 0, 1, 0, 0, 0, 1), 0, zero_ok});
    rows.push_back('{mk(-ONE, -ONE, -ONE, 0, 0, 0, 0, -1, ONE, ONE, ONE, 1), 0, zero_ok});
    // saturating sums: each node adds half of the limit on one axis
    for (int i = 0; i < 6; i++)
      rows.push_back('{mk(32, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, i == 5), 0, zero_ok});

    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) send_node(rows[i].n, rows[i].typed, rows[i].a);
    drain();

    write_reg(sgff_pkg::REG_SOFTENING, 32'h7fff_ffff);
    write_reg(sgff_pkg::REG_GRAVITY, 32'hffff_ffff);
    random_groups(300, 0);
    drain();

    write_reg(sgff_pkg::REG_SOFTENING, 32'h0);
    write_reg(sgff_pkg::REG_GRAVITY, 32'h1);
    random_groups(300, 1);
    drain();

    write_reg(sgff_pkg::REG_SOFTENING, {1'b0, 31'($urandom)});
    write_reg(sgff_pkg::REG_GRAVITY, $urandom_range(1, 32'hffff_ffff));
    random_groups(300, 0);
    drain();

    write_reg(sgff_pkg::REG_SOFTENING, 32'h0010_0000);
    write_reg(sgff_pkg::REG_GRAVITY, 32'h0100_0000);
    random_groups(350, 0);
    drain();

    write_reg(sgff_pkg::REG_SOFTENING, 32'h0);
    write_reg(sgff_pkg::REG_GRAVITY, 32'h0100_0000);
    random_groups(350, 0);
    drain();

    if (mismatches == 0 && accel_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
